// ===== design/fat_long_name_assembler_defines.svh =====
// Assertion macros used by the assembler.
`ifndef FAT_LONG_NAME_ASSEMBLER_DEFINES_SVH
`define FAT_LONG_NAME_ASSEMBLER_DEFINES_SVH

// Same-cycle implication.
`define FLNA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assembler check failed");

// Next-cycle implication.
`define FLNA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assembler check failed");

`endif

// ===== design/flna_pkg.sv =====
package flna_pkg;

  localparam int NAME_STORE_BYTES = 256;
  localparam int MAX_CHUNKS       = 32;
  localparam int LEN_LIMIT        = 8 * MAX_CHUNKS;
  localparam int ADDR_W           = $clog2(NAME_STORE_BYTES);
  localparam int POS_W            = ADDR_W + 1;
  localparam int SCAN_W           = $clog2(LEN_LIMIT + 1);
  localparam int NUM_CHARS        = 13;

  localparam logic [15:0] PAD_CHAR       = 16'hFFFF;
  localparam logic [7:0]  ORD_LAST_ONLY  = 8'h01;
  localparam logic [7:0]  ORD_LAST_FIRST = 8'h41;

  // Byte offsets of the characters, in store order (name3, name2, name1, backwards).
  localparam int CHAR_OFF [NUM_CHARS] = '{30, 28, 24, 22, 20, 18, 16, 14, 9, 7, 5, 3, 1};

endpackage

// ===== design/flna_ram.sv =====
module flna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/flna_lane.sv =====
module flna_lane import flna_pkg::*; (
  input  logic [15:0] chr,
  output logic [7:0]  ch_low,
  output logic        keep
);

  // Drop padding, hold the low byte of anything else.
  assign keep   = (chr != PAD_CHAR);
  assign ch_low = chr[7:0];

endmodule

// ===== design/fat_long_name_assembler.sv =====
// Long-name assembler. Pulse start with one 32-byte long-name directory entry while busy is
// low; entries go in on-disk order, last part of the name first. Thirteen lanes decode the
// entry's characters at once, then the characters are written into the name store one per
// cycle while busy stays high. An entry with order 0x01 or 0x41 closes the name: unless the
// name overflowed or is empty, the top byte is checked through the store's registered read
// port, then the name streams out at one byte per cycle until its terminator; a name that
// could exceed the word limit is first scanned for its length. Results appear on name_chunk,
// chunk_length, name_status and last_chunk for exactly one cycle with done high; the
// receiver cannot stall, so it must take every word as it comes. A corrupt or overflowed
// name gives one word with name_status set; an empty name gives one empty word. The name
// store needs no clearing after reset.
`include "fat_long_name_assembler_defines.svh"

module fat_long_name_assembler import flna_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] entry_bytes_0_7,
  input  logic [63:0] entry_bytes_8_15,
  input  logic [63:0] entry_bytes_16_23,
  input  logic [63:0] entry_bytes_24_31,
  output logic        done,
  output logic [63:0] name_chunk,
  output logic [3:0]  chunk_length,
  output logic        name_status,
  output logic        last_chunk
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WRITE = 3'd1;
  localparam logic [2:0] S_END   = 3'd2;
  localparam logic [2:0] S_TOP   = 3'd3;
  localparam logic [2:0] S_STRM  = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;

  localparam logic [POS_W-1:0] TOP_POS  = POS_W'(NAME_STORE_BYTES - 1);
  localparam logic [POS_W-1:0] EXH_POS  = POS_W'(NAME_STORE_BYTES);
  localparam logic [3:0]       SLOT_END = 4'(NUM_CHARS - 1);

  logic [2:0]        state;
  logic [255:0]      entry;
  logic [7:0]        lane_low  [NUM_CHARS];
  logic              lane_keep [NUM_CHARS];
  logic [7:0]        slot_low  [NUM_CHARS];
  logic              slot_keep [NUM_CHARS];
  logic [3:0]        slot;
  logic              term;
  logic              in_prog;
  logic              ovf;
  logic [POS_W-1:0]  wp;
  logic [POS_W-1:0]  start_pos;
  logic [POS_W-1:0]  pos;
  logic              pend;
  logic [63:0]       chunk_buf;
  logic [3:0]        chunk_cnt;
  logic [SCAN_W-1:0] scan_cnt;
  logic [POS_W-1:0]  written;
  logic [POS_W-1:0]  first_pos;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        rdata;

  assign entry = {entry_bytes_24_31, entry_bytes_16_23, entry_bytes_8_15, entry_bytes_0_7};
  assign busy  = (state != S_IDLE);

  // Decode all thirteen characters side by side.
  for (genvar g = 0; g < NUM_CHARS; g++) begin : g_lane
    flna_lane u_lane (
      .chr    (entry[8*CHAR_OFF[g] +: 16]),
      .ch_low (lane_low[g]),
      .keep   (lane_keep[g])
    );
  end

  assign written   = wp[ADDR_W] ? EXH_POS : (TOP_POS - wp);
  assign first_pos = wp[ADDR_W] ? '0 : (wp + POS_W'(1));

  // One store write per kept character; exhausted store takes nothing.
  assign we    = (state == S_WRITE) && slot_keep[slot] && !wp[ADDR_W];
  assign waddr = wp[ADDR_W-1:0];

  always_comb begin
    raddr = pos[ADDR_W-1:0];
    unique case (state)
      S_END:   raddr = TOP_POS[ADDR_W-1:0];
      S_TOP:   raddr = first_pos[ADDR_W-1:0];
      default: raddr = pos[ADDR_W-1:0];
    endcase
    if (state == S_SCAN && (!pend || rdata == 8'd0)) begin
      raddr = start_pos[ADDR_W-1:0];
    end
  end

  flna_ram #(.WIDTH(8), .DEPTH(NAME_STORE_BYTES)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (slot_low[slot]),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      in_prog <= 1'b0;
      ovf     <= 1'b0;
      wp      <= TOP_POS;
      done    <= 1'b0;
      pend    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            // Latch the lanes and open a name if none is open.
            for (int k = 0; k < NUM_CHARS; k++) begin
              slot_low[k]  <= lane_low[k];
              slot_keep[k] <= lane_keep[k];
            end
            slot    <= '0;
            term    <= (entry[7:0] == ORD_LAST_ONLY) || (entry[7:0] == ORD_LAST_FIRST);
            in_prog <= 1'b1;
            if (!in_prog) begin
              wp  <= TOP_POS;
              ovf <= 1'b0;
            end
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (slot_keep[slot]) begin
            if (wp[ADDR_W]) begin
              ovf <= 1'b1;
            end else if (wp == '0) begin
              wp <= EXH_POS;
            end else begin
              wp <= wp - POS_W'(1);
            end
          end
          slot <= slot + 4'd1;
          if (slot == SLOT_END) begin
            state <= S_END;
          end
        end
        S_END: begin
          if (!term) begin
            state <= S_IDLE;
          end else begin
            in_prog <= 1'b0;
            if (ovf || wp == TOP_POS) begin
              done         <= 1'b1;
              name_chunk   <= '0;
              chunk_length <= '0;
              name_status  <= ovf;
              last_chunk   <= 1'b1;
              state        <= S_IDLE;
            end else begin
              state <= S_TOP;
            end
          end
        end
        S_TOP: begin
          if (rdata != 8'd0) begin
            done         <= 1'b1;
            name_chunk   <= '0;
            chunk_length <= '0;
            name_status  <= 1'b1;
            last_chunk   <= 1'b1;
            state        <= S_IDLE;
          end else begin
            start_pos <= first_pos;
            pos       <= first_pos + POS_W'(1);
            pend      <= 1'b1;
            chunk_buf <= '0;
            chunk_cnt <= '0;
            scan_cnt  <= '0;
            state     <= (32'(written) > 32'(LEN_LIMIT)) ? S_SCAN : S_STRM;
          end
        end
        S_SCAN: begin
          // Length pre-check for names that could exceed the word limit.
          if (!pend || rdata == 8'd0) begin
            pos   <= start_pos + POS_W'(1);
            pend  <= 1'b1;
            state <= S_STRM;
          end else if (scan_cnt == SCAN_W'(LEN_LIMIT)) begin
            done         <= 1'b1;
            name_chunk   <= '0;
            chunk_length <= '0;
            name_status  <= 1'b1;
            last_chunk   <= 1'b1;
            state        <= S_IDLE;
          end else begin
            scan_cnt <= scan_cnt + SCAN_W'(1);
            pend     <= !pos[ADDR_W];
            if (!pos[ADDR_W]) begin
              pos <= pos + POS_W'(1);
            end
          end
        end
        S_STRM: begin
          pend <= !pos[ADDR_W];
          if (!pos[ADDR_W]) begin
            pos <= pos + POS_W'(1);
          end
          if (!pend || rdata == 8'd0) begin
            // End of name: flush what is held as the last word.
            done         <= 1'b1;
            name_chunk   <= chunk_buf;
            chunk_length <= chunk_cnt;
            name_status  <= 1'b0;
            last_chunk   <= 1'b1;
            state        <= S_IDLE;
          end else if (chunk_cnt == 4'd8) begin
            done         <= 1'b1;
            name_chunk   <= chunk_buf;
            chunk_length <= 4'd8;
            name_status  <= 1'b0;
            last_chunk   <= 1'b0;
            chunk_buf    <= {56'd0, rdata};
            chunk_cnt    <= 4'd1;
          end else begin
            chunk_buf[{chunk_cnt[2:0], 3'b000} +: 8] <= rdata;
            chunk_cnt <= chunk_cnt + 4'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `FLNA_ASSERT_NOW(a_mid_full, done && !last_chunk, chunk_length == 4'd8 && !name_status)
  `FLNA_ASSERT_NOW(a_bad_empty, done && name_status, chunk_length == 4'd0 && name_chunk == '0)
  `FLNA_ASSERT_NOW(a_empty_last, done && chunk_length == 4'd0, last_chunk)
  `FLNA_ASSERT_NEXT(a_take_busy, start && !busy, busy)

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import flna_pkg::*;

  // Clock, reset and block ports; every input starts at a known value.
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [63:0] entry_bytes_0_7 = '0;
  logic [63:0] entry_bytes_8_15 = '0;
  logic [63:0] entry_bytes_16_23 = '0;
  logic [63:0] entry_bytes_24_31 = '0;
  logic        done;
  logic [63:0] name_chunk;
  logic [3:0]  chunk_length;
  logic        name_status;
  logic        last_chunk;

  fat_long_name_assembler DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .entry_bytes_0_7(entry_bytes_0_7),
    .entry_bytes_8_15(entry_bytes_8_15),
    .entry_bytes_16_23(entry_bytes_16_23),
    .entry_bytes_24_31(entry_bytes_24_31),
    .done(done),
    .name_chunk(name_chunk),
    .chunk_length(chunk_length),
    .name_status(name_status),
    .last_chunk(last_chunk)
  );

  localparam logic [15:0] FILL_CHAR = 16'hFFFF;
  localparam logic [15:0] NUL_CHAR  = 16'h0000;
  localparam logic [7:0]  ORD_FIRST_MARK = 8'h40;
  localparam int          ITEM_TARGET = 200;

  // One directory entry as queued for the driver. wait_drain holds the entry back until
  // every outstanding word has come out of the block.
  typedef struct {
    logic [255:0] raw;
    bit           wait_drain;
  } dir_entry_t;

  // One word of the assembled name as it should leave the block.
  typedef struct {
    logic [63:0] chunk;
    logic [3:0]  len;
    logic        status;
    logic        last;
  } name_word_t;

  dir_entry_t entry_queue[$];
  name_word_t expected_words[$];
  int         mismatches = 0;

  // Shadow copy of the block's name store and its bookkeeping.
  logic [7:0] shadow_store [NAME_STORE_BYTES];
  int         shadow_wpos = NAME_STORE_BYTES - 1;
  bit         shadow_open = 1'b0;
  bit         shadow_overflow = 1'b0;

  // Byte offsets of the 13 characters in name order: name1, name2, name3.
  int slot_offset [13] = '{1, 3, 5, 7, 9, 14, 16, 18, 20, 22, 24, 28, 30};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < NAME_STORE_BYTES; i++) shadow_store[i] = 8'h00;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Push one expected word.
  task automatic expect_word(input logic [63:0] chunk, input int len, input bit status,
                             input bit last);
    name_word_t w;
    w.chunk = chunk;
    w.len = len[3:0];
    w.status = status;
    w.last = last;
    expected_words.push_back(w);
  endtask

  // Store one character's low byte, dropping padding and anything past an exhausted store.
  task automatic store_char(input logic [15:0] c);
    if (c == FILL_CHAR) return;
    if (shadow_wpos >= NAME_STORE_BYTES) begin
      shadow_overflow = 1'b1;
      return;
    end
    shadow_store[shadow_wpos] = c[7:0];
    shadow_wpos = (shadow_wpos == 0) ? NAME_STORE_BYTES : shadow_wpos - 1;
  endtask

  // Absorb one accepted entry and queue whatever words it causes.
  task automatic assemble_entry(input logic [255:0] e);
    int top;
    int first;
    int len;
    int take;
    logic [63:0] chunk;
    logic [7:0] ord;
    top = NAME_STORE_BYTES - 1;
    if (!shadow_open) begin
      shadow_open = 1'b1;
      shadow_wpos = top;
      shadow_overflow = 1'b0;
    end
    // Walk the characters backwards: name3, then name2, then name1.
    for (int s = 12; s >= 0; s--) store_char(e[8*slot_offset[s] +: 16]);
    ord = e[7:0];
    if (ord != ORD_LAST_ONLY && ord != ORD_LAST_FIRST) return;
    shadow_open = 1'b0;
    if (shadow_overflow) begin
      expect_word('0, 0, 1'b1, 1'b1);
      return;
    end
    if (shadow_wpos == top) begin
      expect_word('0, 0, 1'b0, 1'b1);
      return;
    end
    if (shadow_store[top] != 8'h00) begin
      expect_word('0, 0, 1'b1, 1'b1);
      return;
    end
    first = (shadow_wpos >= NAME_STORE_BYTES) ? 0 : shadow_wpos + 1;
    len = 0;
    while (first + len <= top && shadow_store[first + len] != 8'h00) len++;
    if (len == 0) begin
      expect_word('0, 0, 1'b0, 1'b1);
      return;
    end
    if (len > LEN_LIMIT) begin
      expect_word('0, 0, 1'b1, 1'b1);
      return;
    end
    for (int i = 0; i < len; i += 8) begin
      take = (len - i < 8) ? len - i : 8;
      chunk = '0;
      for (int j = 0; j < take; j++) chunk[8*j +: 8] = shadow_store[first + i + j];
      expect_word(chunk, take, 1'b0, i + take >= len);
    end
  endtask

  function automatic logic [255:0] random_raw();
    logic [255:0] r;
    for (int k = 0; k < 8; k++) r[32*k +: 32] = $urandom;
    return r;
  endfunction

  // Mostly printable characters, now and then any 16-bit value.
  function automatic logic [15:0] pick_char();
    if ($urandom_range(0, 9) < 8) return {8'h00, 8'($urandom_range(8'h20, 8'h7E))};
    return 16'($urandom);
  endfunction

  // Queue a name of nlen characters, split into entries, last part first. Leave off the
  // closing entry when close_it is clear, so the next name runs on into this one.
  task automatic queue_name(input int nlen, input bit close_it, input bit drain_first);
    logic [15:0] chars[$];
    int          nent;
    dir_entry_t  d;
    for (int k = 0; k < nlen; k++) chars.push_back(pick_char());
    // A name that fills its entries exactly carries no terminator.
    if (nlen == 0 || nlen % 13 != 0) chars.push_back(NUL_CHAR);
    while (chars.size() % 13 != 0) chars.push_back(FILL_CHAR);
    nent = chars.size() / 13;
    for (int j = nent; j >= 1; j--) begin
      if (j == 1 && !close_it) break;
      d.raw = random_raw();
      d.raw[7:0] = 8'(j) | ((j == nent) ? ORD_FIRST_MARK : 8'h00);
      for (int s = 0; s < 13; s++) d.raw[8*slot_offset[s] +: 16] = chars[(j-1)*13 + s];
      d.wait_drain = drain_first && (j == nent);
      entry_queue.push_back(d);
    end
  endtask

  // Queue one entry with fully random content; its order byte rarely closes a name.
  task automatic queue_noise();
    dir_entry_t d;
    d.raw = random_raw();
    d.wait_drain = 1'b0;
    entry_queue.push_back(d);
  endtask

  task automatic queue_single(input logic [255:0] raw);
    dir_entry_t d;
    d.raw = raw;
    d.wait_drain = 1'b0;
    entry_queue.push_back(d);
  endtask

  // Build the stimulus: a directed opening, then random names with some noise.
  initial begin
    logic [255:0] r;
    int pick;
    int nlen;
    // Single entry of nothing but padding: an empty name.
    r = {256{1'b1}};
    r[7:0] = ORD_LAST_FIRST;
    queue_single(r);
    // All-zero entry that still closes: first byte of the name is zero.
    r = '0;
    r[7:0] = ORD_LAST_FIRST;
    queue_single(r);
    // All ones except the order byte: padding only, closing with the plain last order.
    r = {256{1'b1}};
    r[7:0] = ORD_LAST_ONLY;
    queue_single(r);
    queue_name(0, 1'b1, 1'b0);
    queue_name(1, 1'b1, 1'b0);
    queue_name(8, 1'b1, 1'b0);
    queue_name(12, 1'b1, 1'b0);
    // Exactly 13 characters: no terminator, so the top byte is usually nonzero.
    queue_name(13, 1'b1, 1'b0);
    queue_name(17, 1'b1, 1'b1);
    queue_name(25, 1'b1, 1'b0);
    // Open a name, drop its closing entry, then a noise entry runs into the next name.
    queue_name(20, 1'b0, 1'b0);
    queue_noise();
    queue_name(5, 1'b1, 1'b0);
    // Random part: mostly well-formed names, a few long ones that fill or overflow.
    while (entry_queue.size() < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) nlen = $urandom_range(0, 40);
      else if (pick < 80) nlen = $urandom_range(41, 160);
      else if (pick < 90) nlen = $urandom_range(240, 262);
      else nlen = -1;
      if (nlen < 0) queue_noise();
      else queue_name(nlen, $urandom_range(0, 9) != 0, $urandom_range(0, 11) == 0);
    end
    // Finish with a full store: 255 characters and a terminator, the longest name.
    queue_name(255, 1'b1, 1'b1);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // Driver: take one entry off the queue per handshake, with random gaps in between.
  int gap_left = 0;
  bit burst_mode = 1'b0;

  always @(posedge clk) begin
    bit accepted;
    bit can_issue;
    if (rst) begin
      start <= 1'b0;
    end else begin
      accepted = start && !busy;
      if (accepted) begin
        assemble_entry(entry_queue[0].raw);
        void'(entry_queue.pop_front());
      end
      if (start && !accepted) begin
        // Hold the word until the block takes it.
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else begin
        can_issue = entry_queue.size() != 0 &&
                    (!entry_queue[0].wait_drain || expected_words.size() == 0);
        start <= can_issue;
        if (can_issue) begin
          entry_bytes_0_7   <= entry_queue[0].raw[63:0];
          entry_bytes_8_15  <= entry_queue[0].raw[127:64];
          entry_bytes_16_23 <= entry_queue[0].raw[191:128];
          entry_bytes_24_31 <= entry_queue[0].raw[255:192];
          // Switch now and then between back-to-back bursts and gappy traffic.
          if ($urandom_range(0, 19) == 0) burst_mode = !burst_mode;
          if (burst_mode) gap_left <= 0;
          else if ($urandom_range(0, 9) == 0) gap_left <= $urandom_range(20, 80);
          else gap_left <= $urandom_range(0, 3);
        end
      end
    end
  end

  // Monitor: every word on done is checked against the oldest expectation.
  always @(posedge clk) begin
    name_word_t w;
    if (!rst && done) begin
      if (expected_words.size() == 0) begin
        report_mismatch("word with nothing expected");
      end else begin
        w = expected_words.pop_front();
        if (name_chunk !== w.chunk)
          report_mismatch($sformatf("name_chunk %h, want %h", name_chunk, w.chunk));
        if (chunk_length !== w.len)
          report_mismatch($sformatf("chunk_length %0d, want %0d", chunk_length, w.len));
        if (name_status !== w.status)
          report_mismatch($sformatf("name_status %b, want %b", name_status, w.status));
        if (last_chunk !== w.last)
          report_mismatch($sformatf("last_chunk %b, want %b", last_chunk, w.last));
      end
    end
  end

  // End of run: all entries in, all words out, then a quiet tail for stray words.
  initial begin
    @(negedge rst);
    while (entry_queue.size() != 0 || start) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (expected_words.size() != 0) report_mismatch("words still expected at the end");
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/flna_pkg.sv
design/flna_ram.sv
design/flna_lane.sv
design/fat_long_name_assembler.sv
test/tb_top.sv
